### src/mbw_pkg.sv
package mbw_pkg;

  // grid bounds
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;

  // zero-based coordinate and counter widths
  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CELL_W = COL_W + ROW_W;
  localparam int CNT_W  = $clog2(CELLS + 1);

  // port field widths
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 16;
  localparam int OUT_W     = 7;

  // grid size latched out of reset (register reset value 64, saturated)
  localparam int RST_COLS = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int RST_ROWS = (MAX_ROWS < 64) ? MAX_ROWS : 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLS      = 3'd0,
    CFG_ROWS      = 3'd1,
    CFG_START_COL = 3'd2,
    CFG_START_ROW = 3'd3
  } cfg_idx_e;

  // walk sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD1,
    S_EVAL,
    S_OUT
  } state_e;

  // neighbor directions in list order
  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_LEFT,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  // neighbor choice
  typedef struct packed {
    logic found;
    dir_e dir;
  } pick_t;

endpackage

### src/mbw_visit_ram.sv
module mbw_visit_ram (
  input  logic                          clk_i,
  input  logic                          ra_en_i,
  input  logic [mbw_pkg::ROW_W-1:0]     ra_addr_i,
  output logic [mbw_pkg::MAX_COLS-1:0]  ra_data_o,
  input  logic                          rb_en_i,
  input  logic [mbw_pkg::ROW_W-1:0]     rb_addr_i,
  output logic [mbw_pkg::MAX_COLS-1:0]  rb_data_o,
  input  logic                          we_i,
  input  logic [mbw_pkg::ROW_W-1:0]     waddr_i,
  input  logic [mbw_pkg::MAX_COLS-1:0]  wdata_i
);

  // one word per grid row, one bit per column
  logic [mbw_pkg::MAX_COLS-1:0] mem [mbw_pkg::MAX_ROWS];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // two registered read ports
  always_ff @(posedge clk_i) begin
    if (ra_en_i) begin
      ra_data_o <= mem[ra_addr_i];
    end
    if (rb_en_i) begin
      rb_data_o <= mem[rb_addr_i];
    end
  end

endmodule

### src/mbw_stack_ram.sv
module mbw_stack_ram (
  input  logic                         clk_i,
  input  logic                         re_i,
  input  logic [mbw_pkg::CELL_W-1:0]   raddr_i,
  output logic [mbw_pkg::CELL_W-1:0]   rdata_o,
  input  logic                         we_i,
  input  logic [mbw_pkg::CELL_W-1:0]   waddr_i,
  input  logic [mbw_pkg::CELL_W-1:0]   wdata_i
);

  // path entries as {row, col}, zero based
  logic [mbw_pkg::CELL_W-1:0] mem [mbw_pkg::CELLS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### src/mbw_neighbor_pick.sv
module mbw_neighbor_pick (
  input  logic [mbw_pkg::MAX_COLS-1:0] mid_row_i,
  input  logic [mbw_pkg::MAX_COLS-1:0] up_row_i,
  input  logic [mbw_pkg::MAX_COLS-1:0] down_row_i,
  input  logic [mbw_pkg::COL_W-1:0]    cur_col_i,
  input  logic [mbw_pkg::ROW_W-1:0]    cur_row_i,
  input  logic [mbw_pkg::COL_W-1:0]    last_col_i,
  input  logic [mbw_pkg::ROW_W-1:0]    last_row_i,
  input  logic [mbw_pkg::FRAC_W-1:0]   frac_i,
  output mbw_pkg::pick_t               pick_o
);

  logic [3:0]                      free;
  logic [2:0]                      n_free;
  logic [mbw_pkg::FRAC_W+2:0]      prod;
  logic [1:0]                      pick_idx;
  logic [mbw_pkg::COL_W-1:0]       col_right;
  logic [mbw_pkg::COL_W-1:0]       col_left;

  assign col_right = cur_col_i + mbw_pkg::COL_W'(1);
  assign col_left  = cur_col_i - mbw_pkg::COL_W'(1);

  // free neighbors in the order right, left, up, down
  always_comb begin
    free[0] = (cur_col_i != last_col_i) && !mid_row_i[col_right];
    free[1] = (cur_col_i != '0) && !mid_row_i[col_left];
    free[2] = (cur_row_i != '0) && !up_row_i[cur_col_i];
    free[3] = (cur_row_i != last_row_i) && !down_row_i[cur_col_i];
  end

  assign n_free   = 3'(free[0]) + 3'(free[1]) + 3'(free[2]) + 3'(free[3]);
  assign prod     = (mbw_pkg::FRAC_W+3)'(frac_i) * (mbw_pkg::FRAC_W+3)'(n_free);
  assign pick_idx = prod[mbw_pkg::FRAC_W+1:mbw_pkg::FRAC_W];

  // select the free neighbor whose rank equals the pick
  always_comb begin
    logic [1:0] rank;
    rank = '0;
    pick_o.found = (n_free != '0);
    pick_o.dir   = mbw_pkg::DIR_RIGHT;
    for (int i = 0; i < 4; i++) begin
      if (free[i]) begin
        if (rank == pick_idx) begin
          pick_o.dir = mbw_pkg::dir_e'(i[1:0]);
        end
        rank = rank + 2'd1;
      end
    end
  end

endmodule

### src/maze_backtracker_walk.sv
// channel   dir  signals                        request
// s_axis    in   tvalid tready tdata tuser      one walk step or restart
// m_axis    out  tvalid tready tdata tuser      current cell after the step
// cfg       in   valid ready addr data          register write, always ready
//
// a walk step reads visited rows r and r-1 plus the stack entry, then row r+1,
// then writes the choice back and loads the result; three rows over the two
// read ports of the visited memory force the second read. a step after
// completion goes straight to the result. a restart and the reset both run a
// clearing pass over the MAX_ROWS visited rows (64 here) with no step
// accepted. a stalled result holds in the output register and the next
// step is taken meanwhile, waiting at its own result until the register frees.
module maze_backtracker_walk (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: random_fraction[15:0]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [mbw_pkg::FRAC_W-1:0]        s_axis_tdata_i,
  // tuser: restart[0]
  input  logic [0:0]                        s_axis_tuser_i,
  // tdata: cell_col[6:0], cell_row[13:7], zero[15:14]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [15:0]                       m_axis_tdata_o,
  // tuser: backtracked[0], finished[1]
  output logic [1:0]                        m_axis_tuser_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mbw_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [mbw_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int COL_W  = mbw_pkg::COL_W;
  localparam int ROW_W  = mbw_pkg::ROW_W;
  localparam int CELL_W = mbw_pkg::CELL_W;
  localparam int CNT_W  = mbw_pkg::CNT_W;
  localparam int WORD_W = mbw_pkg::MAX_COLS;
  localparam int OUT_W_LOC = mbw_pkg::OUT_W;
  localparam logic [ROW_W-1:0] LAST_CLR = ROW_W'(mbw_pkg::MAX_ROWS - 1);

  function automatic logic [31:0] clamp_to(logic [31:0] v, logic [31:0] hi);
    logic [31:0] r;
    if (v == 32'd0) begin
      r = 32'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  mbw_pkg::state_e state_q, state_d;

  logic [mbw_pkg::CFG_W-1:0] cfg_cols_q, cfg_rows_q, cfg_scol_q, cfg_srow_q;
  logic [COL_W-1:0]          last_col_q, cur_col_q;
  logic [ROW_W-1:0]          last_row_q, cur_row_q, clr_cnt_q;
  logic [CNT_W-1:0]          total_q, depth_q, vcount_q;
  logic                      emit_q, back_q;
  logic [mbw_pkg::FRAC_W-1:0] frac_q;
  logic [WORD_W-1:0]         mid_q, up_q;
  logic                      out_valid_q;
  logic [OUT_W_LOC-1:0]      out_col_q, out_row_q;
  logic                      out_back_q, out_fin_q;

  logic in_acc, out_acc, restart, finished;

  // memory controls
  logic              ra_en, rb_en, vis_we;
  logic [ROW_W-1:0]  ra_addr, rb_addr, vis_waddr;
  logic [WORD_W-1:0] ra_data, rb_data, vis_wdata;
  logic              st_re, st_we;
  logic [CELL_W-1:0] st_raddr, st_waddr, st_wdata, st_rdata;

  mbw_pkg::pick_t    pick;
  logic [COL_W-1:0]  new_col;
  logic [ROW_W-1:0]  new_row;
  logic              load_out;

  // restart latching of grid and start cell
  logic [31:0] g_cols, g_rows, s_col, s_row;
  logic [CNT_W-1:0] g_total;

  assign g_cols  = clamp_to(32'(cfg_cols_q), 32'(mbw_pkg::MAX_COLS));
  assign g_rows  = clamp_to(32'(cfg_rows_q), 32'(mbw_pkg::MAX_ROWS));
  assign s_col   = clamp_to(32'(cfg_scol_q), g_cols);
  assign s_row   = clamp_to(32'(cfg_srow_q), g_rows);
  assign g_total = CNT_W'((CNT_W+1)'(g_cols) * (CNT_W+1)'(g_rows));

  assign s_axis_tready_o = (state_q == mbw_pkg::S_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc  = out_valid_q && m_axis_tready_i;
  assign restart  = s_axis_tuser_i[0];
  assign finished = (vcount_q >= total_q);
  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q <= mbw_pkg::CFG_W'(64);
      cfg_rows_q <= mbw_pkg::CFG_W'(64);
      cfg_scol_q <= mbw_pkg::CFG_W'(1);
      cfg_srow_q <= mbw_pkg::CFG_W'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        mbw_pkg::CFG_COLS:      cfg_cols_q <= cfg_data_i;
        mbw_pkg::CFG_ROWS:      cfg_rows_q <= cfg_data_i;
        mbw_pkg::CFG_START_COL: cfg_scol_q <= cfg_data_i;
        mbw_pkg::CFG_START_ROW: cfg_srow_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // memories
  mbw_visit_ram u_visit (
    .clk_i     (clk_i),
    .ra_en_i   (ra_en),
    .ra_addr_i (ra_addr),
    .ra_data_o (ra_data),
    .rb_en_i   (rb_en),
    .rb_addr_i (rb_addr),
    .rb_data_o (rb_data),
    .we_i      (vis_we),
    .waddr_i   (vis_waddr),
    .wdata_i   (vis_wdata)
  );

  mbw_stack_ram u_stack (
    .clk_i   (clk_i),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata)
  );

  // neighbor choice from the three rows around the current cell
  mbw_neighbor_pick u_pick (
    .mid_row_i  (mid_q),
    .up_row_i   (up_q),
    .down_row_i (ra_data),
    .cur_col_i  (cur_col_q),
    .cur_row_i  (cur_row_q),
    .last_col_i (last_col_q),
    .last_row_i (last_row_q),
    .frac_i     (frac_q),
    .pick_o     (pick)
  );

  // chosen cell coordinates
  always_comb begin
    new_col = cur_col_q;
    new_row = cur_row_q;
    case (pick.dir)
      mbw_pkg::DIR_RIGHT: new_col = cur_col_q + COL_W'(1);
      mbw_pkg::DIR_LEFT:  new_col = cur_col_q - COL_W'(1);
      mbw_pkg::DIR_UP:    new_row = cur_row_q - ROW_W'(1);
      default:            new_row = cur_row_q + ROW_W'(1);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mbw_pkg::S_CLEAR: begin
        if (clr_cnt_q == LAST_CLR) begin
          state_d = emit_q ? mbw_pkg::S_OUT : mbw_pkg::S_IDLE;
        end
      end
      mbw_pkg::S_IDLE: begin
        if (in_acc) begin
          if (restart) begin
            state_d = mbw_pkg::S_CLEAR;
          end else if (finished) begin
            state_d = mbw_pkg::S_OUT;
          end else begin
            state_d = mbw_pkg::S_RD1;
          end
        end
      end
      mbw_pkg::S_RD1:  state_d = mbw_pkg::S_EVAL;
      mbw_pkg::S_EVAL: state_d = mbw_pkg::S_OUT;
      mbw_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          state_d = mbw_pkg::S_IDLE;
        end
      end
      default: state_d = mbw_pkg::S_IDLE;
    endcase
  end

  // memory controls per state
  always_comb begin
    ra_en     = 1'b0;
    rb_en     = 1'b0;
    ra_addr   = cur_row_q;
    rb_addr   = cur_row_q - ROW_W'(1);
    vis_we    = 1'b0;
    vis_waddr = clr_cnt_q;
    vis_wdata = '0;
    st_re     = 1'b0;
    st_raddr  = depth_q[CELL_W-1:0] - CELL_W'(2);
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = {cur_row_q, cur_col_q};
    load_out  = 1'b0;
    unique case (state_q)
      mbw_pkg::S_CLEAR: begin
        // zero each row, start cell marked; stack base holds the start cell
        vis_we = 1'b1;
        if (clr_cnt_q == cur_row_q) begin
          vis_wdata = WORD_W'(1) << cur_col_q;
        end
        st_we = (clr_cnt_q == '0);
      end
      mbw_pkg::S_IDLE: begin
        if (in_acc && !restart && !finished) begin
          ra_en = 1'b1;
          rb_en = 1'b1;
          st_re = 1'b1;
        end
      end
      mbw_pkg::S_RD1: begin
        ra_en   = 1'b1;
        ra_addr = cur_row_q + ROW_W'(1);
      end
      mbw_pkg::S_EVAL: begin
        if (pick.found) begin
          vis_we    = 1'b1;
          vis_waddr = new_row;
          case (pick.dir) inside
            mbw_pkg::DIR_RIGHT,
            mbw_pkg::DIR_LEFT: vis_wdata = mid_q | (WORD_W'(1) << new_col);
            mbw_pkg::DIR_UP:   vis_wdata = up_q | (WORD_W'(1) << new_col);
            default:           vis_wdata = ra_data | (WORD_W'(1) << new_col);
          endcase
          st_we    = (depth_q < CNT_W'(mbw_pkg::CELLS));
          st_waddr = depth_q[CELL_W-1:0];
          st_wdata = {new_row, new_col};
        end
      end
      mbw_pkg::S_OUT: begin
        load_out = !out_valid_q || m_axis_tready_i;
      end
      default: ;
    endcase
  end

  // walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mbw_pkg::S_CLEAR;
      last_col_q <= COL_W'(mbw_pkg::RST_COLS - 1);
      last_row_q <= ROW_W'(mbw_pkg::RST_ROWS - 1);
      total_q    <= CNT_W'(mbw_pkg::RST_COLS * mbw_pkg::RST_ROWS);
      cur_col_q  <= '0;
      cur_row_q  <= '0;
      depth_q    <= CNT_W'(1);
      vcount_q   <= CNT_W'(1);
      clr_cnt_q  <= '0;
      emit_q     <= 1'b0;
      back_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        mbw_pkg::S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ROW_W'(1);
        end
        mbw_pkg::S_IDLE: begin
          if (in_acc) begin
            back_q <= 1'b0;
            if (restart) begin
              last_col_q <= COL_W'(g_cols - 32'd1);
              last_row_q <= ROW_W'(g_rows - 32'd1);
              total_q    <= g_total;
              cur_col_q  <= COL_W'(s_col - 32'd1);
              cur_row_q  <= ROW_W'(s_row - 32'd1);
              depth_q    <= CNT_W'(1);
              vcount_q   <= CNT_W'(1);
              clr_cnt_q  <= '0;
              emit_q     <= 1'b1;
            end
          end
        end
        mbw_pkg::S_EVAL: begin
          if (pick.found) begin
            cur_col_q <= new_col;
            cur_row_q <= new_row;
            vcount_q  <= vcount_q + CNT_W'(1);
            if (depth_q < CNT_W'(mbw_pkg::CELLS)) begin
              depth_q <= depth_q + CNT_W'(1);
            end
          end else if (depth_q > CNT_W'(1)) begin
            // pop back to the entry below the top
            depth_q   <= depth_q - CNT_W'(1);
            cur_col_q <= st_rdata[COL_W-1:0];
            cur_row_q <= st_rdata[CELL_W-1:COL_W];
            back_q    <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // step payload and captured rows
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frac_q <= s_axis_tdata_i;
    end
    if (state_q == mbw_pkg::S_RD1) begin
      mid_q <= ra_data;
      up_q  <= rb_data;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [31:0] col_1b, row_1b;
    col_1b = 32'(cur_col_q) + 32'd1;
    row_1b = 32'(cur_row_q) + 32'd1;
    if (load_out) begin
      out_col_q  <= col_1b[OUT_W_LOC-1:0];
      out_row_q  <= row_1b[OUT_W_LOC-1:0];
      out_back_q <= back_q;
      out_fin_q  <= finished;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_row_q, out_col_q};
  assign m_axis_tuser_o  = {out_fin_q, out_back_q};

endmodule

### tb/maze_backtracker_walk_tb.sv
`timescale 1ns / 100ps

module maze_backtracker_walk_tb;

  localparam int MAX_COLS  = mbw_pkg::MAX_COLS;
  localparam int MAX_ROWS  = mbw_pkg::MAX_ROWS;
  localparam int CELLS     = mbw_pkg::CELLS;
  localparam int FRAC_W    = mbw_pkg::FRAC_W;
  localparam int OUT_W     = mbw_pkg::OUT_W;
  localparam int CFG_W     = mbw_pkg::CFG_W;
  localparam int CFG_IDX_W = mbw_pkg::CFG_IDX_W;

  localparam int ITEMS_TARGET = 1450;
  localparam int CLEAR_PAUSE  = MAX_ROWS + 16;
  localparam int TAIL_CYCLES  = 16;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_NS   = 1_000_000;
  localparam int STEP_CAP     = 150;

  // unused register indexes sit above the last real one
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd4;

  // receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  // one walk request
  typedef struct packed {
    logic                restart;
    logic [FRAC_W-1:0]   frac;
  } step_req_t;

  // one walk position report
  typedef struct packed {
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] row;
    logic             back;
    logic             fin;
  } walk_pos_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [FRAC_W-1:0]     s_axis_tdata_i;
  logic [0:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [15:0]           m_axis_tdata_o;
  logic [1:0]            m_axis_tuser_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_addr_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;

  step_req_t step_now = '0;
  logic      step_taken = 1'b0;

  step_req_t pending_steps[$];
  walk_pos_t pos_expected[$];

  // walk predictor state
  bit             visited [CELLS];
  logic [OUT_W-1:0] trail_col [CELLS];
  logic [OUT_W-1:0] trail_row [CELLS];
  int             trail_depth;
  int             seen_count;
  int             cur_col, cur_row;
  int             grid_cols, grid_rows;
  logic [CFG_W-1:0] reg_cols, reg_rows, reg_start_col, reg_start_row;

  // run bookkeeping
  int mismatches = 0;
  int items_queued = 0;
  int steps_done = 0;
  int restarts_done = 0;
  int backtracks_seen = 0;
  int finishes_seen = 0;
  int grid_settings = 0;
  int hold_req = 0;

  assign s_axis_tdata_i = step_now.frac;
  assign s_axis_tuser_i = step_now.restart;

  maze_backtracker_walk dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // size and start clamping, zero counts as one
  function automatic int clamp_to(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int map_index(int c, int r);
    return (r - 1) * MAX_COLS + (c - 1);
  endfunction

  // latch grid and start, clear the visited map
  task automatic restart_walk();
    grid_cols = clamp_to(int'(reg_cols), MAX_COLS);
    grid_rows = clamp_to(int'(reg_rows), MAX_ROWS);
    cur_col = clamp_to(int'(reg_start_col), grid_cols);
    cur_row = clamp_to(int'(reg_start_row), grid_rows);
    for (int i = 0; i < CELLS; i++) visited[i] = 1'b0;
    visited[map_index(cur_col, cur_row)] = 1'b1;
    trail_col[0] = OUT_W'(cur_col);
    trail_row[0] = OUT_W'(cur_row);
    trail_depth = 1;
    seen_count = 1;
  endtask

  task automatic walk_reset();
    reg_cols = 7'd64;
    reg_rows = 7'd64;
    reg_start_col = 7'd1;
    reg_start_row = 7'd1;
    restart_walk();
  endtask

  // one step of the randomized depth-first walk
  task automatic predict_step(input step_req_t req, output walk_pos_t res);
    int cand_c[4];
    int cand_r[4];
    int n;
    int pick;
    int total;
    logic back;
    back = 1'b0;
    if (req.restart) begin
      restart_walk();
    end else begin
      total = grid_cols * grid_rows;
      if (seen_count < total) begin
        n = 0;
        // neighbor order: right, left, up, down
        if (cur_col < grid_cols && !visited[map_index(cur_col + 1, cur_row)]) begin
          cand_c[n] = cur_col + 1; cand_r[n] = cur_row; n++;
        end
        if (cur_col > 1 && !visited[map_index(cur_col - 1, cur_row)]) begin
          cand_c[n] = cur_col - 1; cand_r[n] = cur_row; n++;
        end
        if (cur_row > 1 && !visited[map_index(cur_col, cur_row - 1)]) begin
          cand_c[n] = cur_col; cand_r[n] = cur_row - 1; n++;
        end
        if (cur_row < grid_rows && !visited[map_index(cur_col, cur_row + 1)]) begin
          cand_c[n] = cur_col; cand_r[n] = cur_row + 1; n++;
        end
        if (n > 0) begin
          pick = (int'(req.frac) * n) >>> FRAC_W;
          if (pick >= n) pick = n - 1;
          cur_col = cand_c[pick];
          cur_row = cand_r[pick];
          visited[map_index(cur_col, cur_row)] = 1'b1;
          if (trail_depth < CELLS) begin
            trail_col[trail_depth] = OUT_W'(cur_col);
            trail_row[trail_depth] = OUT_W'(cur_row);
            trail_depth++;
          end
          seen_count++;
        end else if (trail_depth > 1) begin
          // dead end, pop back along the trail
          trail_depth--;
          cur_col = int'(trail_col[trail_depth - 1]);
          cur_row = int'(trail_row[trail_depth - 1]);
          back = 1'b1;
        end
      end
    end
    total = grid_cols * grid_rows;
    res.col = OUT_W'(cur_col);
    res.row = OUT_W'(cur_row);
    res.back = back;
    res.fin = (seen_count >= total);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_step(input logic restart, input logic [FRAC_W-1:0] frac);
    step_req_t req;
    req.restart = restart;
    req.frac = frac;
    pending_steps.insert(pending_steps.size(), req);
    items_queued++;
  endtask

  // register write on the config channel, taken into the predictor on acceptance
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mbw_pkg::CFG_COLS:      reg_cols = val;
      mbw_pkg::CFG_ROWS:      reg_rows = val;
      mbw_pkg::CFG_START_COL: reg_start_col = val;
      mbw_pkg::CFG_START_ROW: reg_start_row = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // sender pause until every expected report is back, then let the block settle
  task automatic wait_idle(input int pause);
    while (!(pending_steps.size() == 0 && !s_axis_tvalid_i && pos_expected.size() == 0))
      @(posedge clk_i);
    repeat (pause) @(posedge clk_i);
  endtask

  task automatic write_grid(input int c, input int r, input int sc, input int sr);
    write_reg(mbw_pkg::CFG_COLS, CFG_W'(c));
    write_reg(mbw_pkg::CFG_ROWS, CFG_W'(r));
    write_reg(mbw_pkg::CFG_START_COL, CFG_W'(sc));
    write_reg(mbw_pkg::CFG_START_ROW, CFG_W'(sr));
    grid_settings++;
  endtask

  // request driver, bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (s_axis_tvalid_i && !step_taken) begin
      // hold the request until accepted
    end else if (gap_left > 0) begin
      s_axis_tvalid_i <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_steps.size() != 0) begin
      step_now <= pending_steps.pop_front();
      s_axis_tvalid_i <= 1'b1;
      if (burst_left > 1) begin
        burst_left <= burst_left - 1;
      end else begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // receiver stall pattern plus long hold-offs on demand
  int hold_ack = 0;
  int hold_left = 0;
  int stretch_left = 0;
  rx_mode_e rx_mode = RX_OPEN;
  always @(negedge clk_i) begin
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (stretch_left == 0) begin
        stretch_left <= $urandom_range(20, 200);
        rx_mode <= rx_mode_e'($urandom_range(0, 3));
      end else begin
        stretch_left <= stretch_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_axis_tready_i <= 1'b1;
        RX_LIGHT:  m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  m_axis_tready_i <= ($urandom_range(0, 3) == 0);
        default:   m_axis_tready_i <= ~m_axis_tready_i;
      endcase
    end
  end

  // accepted requests feed the predictor, reports are checked in order
  always @(posedge clk_i) begin : scoreboard
    walk_pos_t res;
    walk_pos_t want;
    step_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      predict_step(step_now, res);
      pos_expected.insert(pos_expected.size(), res);
      if (step_now.restart) restarts_done++;
      else steps_done++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pos_expected.size() == 0) begin
        report_mismatch("report with nothing pending, tdata", int'(m_axis_tdata_o), 0);
      end else begin
        want = pos_expected.pop_front();
        if (m_axis_tdata_o[6:0] !== want.col)
          report_mismatch("cell_col", int'(m_axis_tdata_o[6:0]), int'(want.col));
        if (m_axis_tdata_o[13:7] !== want.row)
          report_mismatch("cell_row", int'(m_axis_tdata_o[13:7]), int'(want.row));
        if (m_axis_tdata_o[15:14] !== 2'b00)
          report_mismatch("tdata padding", int'(m_axis_tdata_o[15:14]), 0);
        if (m_axis_tuser_o[0] !== want.back)
          report_mismatch("backtracked", int'(m_axis_tuser_o[0]), int'(want.back));
        if (m_axis_tuser_o[1] !== want.fin)
          report_mismatch("finished", int'(m_axis_tuser_o[1]), int'(want.fin));
        if (want.back) backtracks_seen++;
        if (want.fin) finishes_seen++;
      end
    end
  end

  // run watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d reports outstanding", pos_expected.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // stimulus: directed cases, then random grids
  initial begin : stimulus
    int phase_no;
    int kind;
    int c_set, r_set, sc_set, sr_set, tmp;
    int cells, nsteps;
    int rnd;
    logic [FRAC_W-1:0] frac;

    walk_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle(CLEAR_PAUSE);

    // new size only takes hold at the next restart
    write_reg(mbw_pkg::CFG_COLS, 7'd3);
    write_reg(mbw_pkg::CFG_ROWS, 7'd3);
    @(posedge clk_i);
    queue_step(1'b0, 16'h0000);
    queue_step(1'b0, 16'hFFFF);
    queue_step(1'b0, 16'h8000);
    queue_step(1'b0, 16'h0000);
    queue_step(1'b0, 16'h5555);
    queue_step(1'b0, 16'hAAAA);
    queue_step(1'b1, 16'hFFFF);
    queue_step(1'b0, 16'h0000);
    queue_step(1'b0, 16'hFFFF);

    // a zero column count and zero start give a single-cell grid, finished at once
    wait_idle(CLEAR_PAUSE);
    write_grid(0, 1, 0, 0);
    @(posedge clk_i);
    queue_step(1'b1, 16'h1234);
    queue_step(1'b0, 16'h0000);
    queue_step(1'b0, 16'hFFFF);

    // oversized grid saturates, start outside the grid clamps to the corner
    wait_idle(CLEAR_PAUSE);
    write_grid(127, 2, 127, 127);
    @(posedge clk_i);
    queue_step(1'b1, 16'h0000);
    queue_step(1'b0, 16'hFFFF);
    queue_step(1'b0, 16'h0000);
    queue_step(1'b0, 16'hFFFF);
    queue_step(1'b0, 16'h0000);

    // single row from the middle: dead end, backtracks, finish and hold
    wait_idle(CLEAR_PAUSE);
    write_grid(5, 1, 3, 1);
    @(posedge clk_i);
    queue_step(1'b1, 16'hFFFF);
    repeat (8) queue_step(1'b0, 16'h0000);

    // random grids, mostly small and walked to completion
    phase_no = 0;
    while (items_queued < ITEMS_TARGET) begin
      phase_no++;
      kind = $urandom_range(0, 99);
      if (phase_no == 3) begin
        c_set = $urandom_range(64, 127);
        r_set = 64;
      end else if (kind < 15) begin
        case ($urandom_range(0, 3))
          0: c_set = 0;
          1: c_set = 1;
          2: c_set = 64;
          default: c_set = $urandom_range(65, 127);
        endcase
        r_set = $urandom_range(0, 3);
        if ($urandom_range(0, 1) == 1) begin
          tmp = c_set; c_set = r_set; r_set = tmp;
        end
      end else begin
        c_set = $urandom_range(1, 8);
        r_set = $urandom_range(1, 8);
      end
      if ($urandom_range(0, 4) == 0) begin
        sc_set = $urandom_range(0, 127);
        sr_set = $urandom_range(0, 127);
      end else begin
        sc_set = $urandom_range(1, clamp_to(c_set, MAX_COLS));
        sr_set = $urandom_range(1, clamp_to(r_set, MAX_ROWS));
      end

      // most phases reconfigure while idle, the rest only restart
      if (phase_no == 3 || $urandom_range(0, 3) != 0) begin
        wait_idle(CLEAR_PAUSE);
        write_grid(c_set, r_set, sc_set, sr_set);
        if ($urandom_range(0, 3) == 0)
          write_reg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(0, 3)),
                    CFG_W'($urandom_range(0, 127)));
        @(posedge clk_i);
      end

      cells = clamp_to(int'(reg_cols), MAX_COLS) * clamp_to(int'(reg_rows), MAX_ROWS);
      nsteps = 2 * cells + $urandom_range(0, 3);
      if (nsteps > STEP_CAP) nsteps = STEP_CAP;
      queue_step(1'b1, FRAC_W'($urandom_range(0, 65535)));
      for (int i = 0; i < nsteps; i++) begin
        rnd = $urandom_range(0, 99);
        if (rnd < 10) frac = 16'h0000;
        else if (rnd < 20) frac = 16'hFFFF;
        else frac = FRAC_W'($urandom_range(0, 65535));
        // a stray restart now and then breaks the walk
        queue_step($urandom_range(0, 99) < 3, frac);
      end

      // receiver holds off while the sender keeps offering
      if (phase_no == 3 || phase_no == 12) hold_req++;
    end

    wait_idle(TAIL_CYCLES);
    $display("walked %0d steps and %0d restarts over %0d grid settings",
             steps_done, restarts_done, grid_settings);
    $display("saw %0d backtracks and %0d reports of a completed maze",
             backtracks_seen, finishes_seen);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
